// File: src/running_lcm_accumulator_core_defines.svh
// Assertion macros for the running LCM accumulator core.
// Include by bare file name; expects clk_i and rst_ni in the including scope.
`ifndef RUNNING_LCM_ACCUMULATOR_CORE_DEFINES_SVH
`define RUNNING_LCM_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RLCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlcm assertion failed");

// Next-cycle implication, checked outside reset.
`define RLCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlcm assertion failed");

`endif

// File: src/rlcm_pkg.sv
// Shared constants for the running LCM accumulator core.
// No dependencies.
package rlcm_pkg;

  localparam int unsigned PERIOD_BITS_DEF = 32;
  localparam int unsigned TASK_PERIOD_W   = 32;
  localparam int unsigned HYPER_W         = 63;
  localparam int unsigned CNT_W           = 6;

  localparam logic [HYPER_W-1:0] HYPER_MAX = '1;

endpackage

// File: src/running_lcm_accumulator_core.sv
// Running LCM accumulator: each accepted transaction folds one task period into
// a running least common multiple (the hyperperiod) and returns one result
// transaction with the updated hyperperiod and a sticky overflow flag. Setting
// start_set_i clears the accumulator and the flag first. Only the low
// min(PERIOD_BITS, 32) bits of task_period_i are used. A zero period yields a
// zero hyperperiod; the next nonzero period is then loaded as is. When the
// product leaves the 63-bit range, the hyperperiod saturates to all ones and
// overflowed_o stays high until the next set start. A small sequencer, whose
// add and subtract steps share one 64-bit adder/subtractor, runs a binary gcd
// (a strip of common factors of two, then subtract/shift/swap until the
// operands are equal), a shift back by the common power of two, a restoring
// division a/gcd and an MSB-first shift-add multiply by the period, then a
// done state that hands the result off; a zero period goes straight to the
// done state. The core takes one transaction at a time: in_stall_o is high
// from acceptance until the result is moved into the output register, which
// holds it for the downstream side while the next transaction enters; a
// stalled output register holds the sequencer in its done state.
// Depends on rlcm_pkg and running_lcm_accumulator_core_defines.svh.
`include "running_lcm_accumulator_core_defines.svh"

module running_lcm_accumulator_core #(
  parameter int unsigned PERIOD_BITS = rlcm_pkg::PERIOD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rlcm_pkg::TASK_PERIOD_W-1:0] task_period_i,
  input  logic                              start_set_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rlcm_pkg::HYPER_W-1:0]      hyperperiod_o,
  output logic                              overflowed_o
);

  localparam int unsigned HW    = rlcm_pkg::HYPER_W;
  localparam int unsigned CW    = rlcm_pkg::CNT_W;
  localparam int unsigned BW    = (PERIOD_BITS < rlcm_pkg::TASK_PERIOD_W) ?
                                  PERIOD_BITS : rlcm_pkg::TASK_PERIOD_W;
  localparam int unsigned ALU_W = HW + 1;
  localparam int unsigned RES_W = HW + 2;

  // Sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_STRIP   = 3'd1;
  localparam logic [2:0] S_GCD     = 3'd2;
  localparam logic [2:0] S_UNSHIFT = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_MUL     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  // Control state
  logic [2:0]    state_q, state_d;
  logic [HW-1:0] running_q, running_d;
  logic          ovf_seen_q, ovf_seen_d;
  logic          out_valid_q;

  // Datapath registers: u/v hold the gcd operands (v ends as the gcd, then the
  // divisor); a holds the dividend and shifts in the quotient; r is the
  // division remainder and then the partial product.
  logic [HW-1:0] u_q, u_d;
  logic [HW-1:0] v_q, v_d;
  logic [HW-1:0] a_q, a_d;
  logic [HW-1:0] r_q, r_d;
  logic [BW-1:0] b_q, b_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          mul_ovf_q, mul_ovf_d;

  logic [HW-1:0] out_hyper_q;
  logic          out_ovf_q;

  // Shared adder/subtractor
  logic [ALU_W-1:0] alu_x, alu_y;
  logic             alu_sub;
  logic [RES_W-1:0] alu_res;
  logic             alu_ge;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic [BW-1:0]    b_in;
  logic [HW-1:0]    b_ext;
  logic [HW-1:0]    base_run;
  logic             base_ovf;
  logic [HW-1:0]    a_init;
  logic [ALU_W-1:0] div_shift;
  logic             mul_step_ovf;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;

  assign b_in     = task_period_i[BW-1:0];
  assign b_ext    = {{(HW-BW){1'b0}}, b_in};
  assign base_run = start_set_i ? '0 : running_q;
  assign base_ovf = start_set_i ? 1'b0 : ovf_seen_q;
  assign a_init   = (base_run == '0) ? b_ext : base_run;

  // Remainder shifted left with the next dividend bit brought in
  assign div_shift = {r_q, a_q[HW-1]};

  // Route operands to the shared unit
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_GCD: begin
        alu_x   = {1'b0, u_q};
        alu_y   = {1'b0, v_q};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_x   = div_shift;
        alu_y   = {1'b0, v_q};
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_x   = {r_q, 1'b0};
        alu_y   = b_q[BW-1] ? {1'b0, a_q} : '0;
        alu_sub = 1'b0;
      end
      default: begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // On subtract, the top bit is the borrow: high means x < y
  assign alu_res = {1'b0, alu_x} + ({1'b0, alu_y} ^ {RES_W{alu_sub}})
                 + {{(RES_W-1){1'b0}}, alu_sub};
  assign alu_ge  = !alu_res[RES_W-1];

  assign mul_step_ovf = |alu_res[RES_W-1:HW];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    running_d  = running_q;
    ovf_seen_d = ovf_seen_q;
    u_d        = u_q;
    v_d        = v_q;
    a_d        = a_q;
    r_d        = r_q;
    b_d        = b_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    mul_ovf_d  = mul_ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          running_d  = base_run;
          ovf_seen_d = base_ovf;
          if (b_in == '0) begin
            // Zero period: product is zero, flag keeps its value
            running_d = '0;
            state_d   = S_DONE;
          end else begin
            u_d     = a_init;
            v_d     = b_ext;
            a_d     = a_init;
            b_d     = b_in;
            k_d     = '0;
            state_d = S_STRIP;
          end
        end
      end
      S_STRIP: begin
        // Drop common factors of two, count them in k
        if (!u_q[0] && !v_q[0]) begin
          u_d = {1'b0, u_q[HW-1:1]};
          v_d = {1'b0, v_q[HW-1:1]};
          k_d = k_q + 1'b1;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (!u_q[0]) begin
          u_d = {1'b0, u_q[HW-1:1]};
        end else if (!v_q[0]) begin
          v_d = {1'b0, v_q[HW-1:1]};
        end else if (!alu_ge) begin
          // u < v: swap, subtract next cycle
          u_d = v_q;
          v_d = u_q;
        end else if (alu_res[HW-1:0] == '0) begin
          state_d = S_UNSHIFT;
        end else begin
          u_d = alu_res[HW-1:0];
        end
      end
      S_UNSHIFT: begin
        // Restore the common power of two into the gcd
        if (k_q == '0) begin
          r_d     = '0;
          cnt_d   = CW'(HW - 1);
          state_d = S_DIV;
        end else begin
          v_d = {v_q[HW-2:0], 1'b0};
          k_d = k_q - 1'b1;
        end
      end
      S_DIV: begin
        r_d = alu_ge ? alu_res[HW-1:0] : div_shift[HW-1:0];
        a_d = {a_q[HW-2:0], alu_ge};
        if (cnt_q == '0) begin
          r_d       = '0;
          cnt_d     = CW'(BW - 1);
          mul_ovf_d = 1'b0;
          state_d   = S_MUL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_MUL: begin
        // Partial products only grow, so any step past the range means overflow
        mul_ovf_d = mul_ovf_q | mul_step_ovf;
        r_d       = alu_res[HW-1:0];
        b_d       = {b_q[BW-2:0], 1'b0};
        if (cnt_q == '0) begin
          if (mul_ovf_d) begin
            running_d  = rlcm_pkg::HYPER_MAX;
            ovf_seen_d = 1'b1;
          end else begin
            running_d = alu_res[HW-1:0];
          end
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      running_q  <= running_d;
      ovf_seen_q <= ovf_seen_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    v_q       <= v_d;
    a_q       <= a_d;
    r_q       <= r_d;
    b_q       <= b_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    mul_ovf_q <= mul_ovf_d;
    if (out_load) begin
      out_hyper_q <= running_q;
      out_ovf_q   <= ovf_seen_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hyperperiod_o = out_hyper_q;
  assign overflowed_o  = out_ovf_q;

  // gcd operands never reach zero inside the subtract loop
  `RLCM_ASSERT_IMPL(a_gcd_nonzero, state_q == S_GCD, (u_q != '0) && (v_q != '0))
  // Restoring division keeps the remainder below the divisor
  `RLCM_ASSERT_IMPL(a_div_rem_bound, state_q == S_DIV, r_q < v_q)
  // A result appears only as the sequencer hands off from its final state
  `RLCM_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE)
  // A finished result leaves the sequencer idle on the next cycle
  `RLCM_ASSERT_NEXT(a_load_to_idle, out_load, state_q == S_IDLE)

endmodule
